@@ rtl/gzhp_pkg.sv @@
// Shared types, codes and the CRC-32 byte update for the gzip header parser.
package gzhp_pkg;

    localparam int unsigned LIMIT_W = 32;
    localparam int unsigned OUT_W   = 48;

    localparam logic [7:0] GZ_ID1      = 8'h1f;
    localparam logic [7:0] GZ_ID2      = 8'h8b;
    localparam logic [7:0] GZ_CM       = 8'h08;
    localparam logic [7:0] FLG_RSVD    = 8'he0;
    localparam logic [7:0] FLG_FEXTRA  = 8'h04;
    localparam logic [7:0] FLG_FNAME   = 8'h08;
    localparam logic [7:0] FLG_FCOMM   = 8'h10;
    localparam logic [7:0] FLG_FHCRC   = 8'h02;
    localparam logic [31:0] CRC_PRESET = 32'hFFFFFFFF;
    localparam logic [31:0] CRC_POLY   = 32'hEDB88320;
    localparam logic [LIMIT_W-1:0] MIN_LIMIT = 32'd10;
    localparam logic [LIMIT_W-1:0] FIXED_LEN = 32'd10;

    localparam logic [2:0] ST_MORE   = 3'd0;
    localparam logic [2:0] ST_DONE   = 3'd1;
    localparam logic [2:0] ST_BADID  = 3'd2;
    localparam logic [2:0] ST_LIMIT  = 3'd3;
    localparam logic [2:0] ST_BADCRC = 3'd4;

    typedef enum logic [12:0] {
        PH_ID1     = 13'h0001,
        PH_ID2     = 13'h0002,
        PH_CM      = 13'h0004,
        PH_FLG     = 13'h0008,
        PH_FIXED   = 13'h0010,
        PH_XLEN0   = 13'h0020,
        PH_XLEN1   = 13'h0040,
        PH_XDATA   = 13'h0080,
        PH_NAME    = 13'h0100,
        PH_COMMENT = 13'h0200,
        PH_CRC0    = 13'h0400,
        PH_CRC1    = 13'h0800,
        PH_HELD    = 13'h1000
    } t_phase;

    typedef enum logic [1:0] {
        FROM_XLEN    = 2'd0,
        FROM_NAME    = 2'd1,
        FROM_COMMENT = 2'd2,
        FROM_CRC     = 2'd3
    } t_from;

    typedef struct packed {
        logic [7:0]         flag_bits;
        logic [LIMIT_W-1:0] header_length;
        logic [2:0]         status;
    } t_result;

    function automatic logic [31:0] crc_update(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

@@ rtl/gzhp_core.sv @@
// Parse state and per-byte next-state logic of the gzip header parser.
module gzhp_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic [7:0]                     i_data_byte,
    input  logic                           i_first,
    input  logic [gzhp_pkg::LIMIT_W-1:0]   i_header_limit,
    output gzhp_pkg::t_result              o_result
);
    import gzhp_pkg::*;

    typedef struct packed {
        t_phase     phase;
        logic [2:0] status;
    } t_step;

    t_phase             r_phase, n_phase, c_phase;
    logic [LIMIT_W-1:0] r_off, n_off, c_off, off_inc;
    logic [31:0]        r_crc, n_crc, c_crc;
    logic [7:0]         r_flags, n_flags, c_flags;
    logic [15:0]        r_xrem, n_xrem, c_xrem, xlen, xdec;
    logic [7:0]         r_crclo, n_crclo, c_crclo;
    logic [2:0]         r_status, n_status, c_status;
    t_step              st;

    function automatic t_step settle(input t_from from, input logic [7:0] flags,
                                     input logic [LIMIT_W-1:0] off,
                                     input logic [LIMIT_W-1:0] lim);
        t_step s;
        logic  two_over;
        logic  at_lim;
        two_over = ({1'b0, off} + (LIMIT_W+1)'(2)) > {1'b0, lim};
        at_lim   = off >= lim;
        s.phase  = PH_HELD;
        s.status = ST_DONE;
        if (from == FROM_XLEN && (flags & FLG_FEXTRA) != 8'd0) begin
            s = two_over ? t_step'{PH_HELD, ST_LIMIT} : t_step'{PH_XLEN0, ST_MORE};
        end else if (from <= FROM_NAME && (flags & FLG_FNAME) != 8'd0) begin
            s = at_lim ? t_step'{PH_HELD, ST_LIMIT} : t_step'{PH_NAME, ST_MORE};
        end else if (from <= FROM_COMMENT && (flags & FLG_FCOMM) != 8'd0) begin
            s = at_lim ? t_step'{PH_HELD, ST_LIMIT} : t_step'{PH_COMMENT, ST_MORE};
        end else if ((flags & FLG_FHCRC) != 8'd0) begin
            s = two_over ? t_step'{PH_HELD, ST_LIMIT} : t_step'{PH_CRC0, ST_MORE};
        end
        return s;
    endfunction

    always_comb begin
        c_phase  = i_first ? PH_ID1 : r_phase;
        c_off    = i_first ? '0 : r_off;
        c_crc    = i_first ? CRC_PRESET : r_crc;
        c_flags  = i_first ? 8'd0 : r_flags;
        c_xrem   = i_first ? 16'd0 : r_xrem;
        c_crclo  = i_first ? 8'd0 : r_crclo;
        c_status = i_first ? ST_MORE : r_status;

        off_inc  = c_off + LIMIT_W'(1);
        xlen     = {i_data_byte, c_xrem[7:0]};
        xdec     = c_xrem - 16'd1;
        st       = '{PH_HELD, ST_MORE};

        n_phase  = c_phase;
        n_off    = c_off;
        n_crc    = c_crc;
        n_flags  = c_flags;
        n_xrem   = c_xrem;
        n_crclo  = c_crclo;
        n_status = c_status;

        if (c_phase != PH_HELD) begin
            if (c_phase != PH_CRC0 && c_phase != PH_CRC1) begin
                n_crc = crc_update(c_crc, i_data_byte);
            end
            case (c_phase)
                PH_ID1: begin
                    if (i_header_limit < MIN_LIMIT) begin
                        n_phase  = PH_HELD;
                        n_status = ST_LIMIT;
                    end else if (i_data_byte != GZ_ID1) begin
                        n_phase  = PH_HELD;
                        n_status = ST_BADID;
                    end else begin
                        n_off   = off_inc;
                        n_phase = PH_ID2;
                    end
                end
                PH_ID2: begin
                    if (i_data_byte != GZ_ID2) begin
                        n_phase  = PH_HELD;
                        n_status = ST_BADID;
                    end else begin
                        n_off   = off_inc;
                        n_phase = PH_CM;
                    end
                end
                PH_CM: begin
                    if (i_data_byte != GZ_CM) begin
                        n_phase  = PH_HELD;
                        n_status = ST_BADID;
                    end else begin
                        n_off   = off_inc;
                        n_phase = PH_FLG;
                    end
                end
                PH_FLG: begin
                    n_flags = i_data_byte;
                    if ((i_data_byte & FLG_RSVD) != 8'd0) begin
                        n_phase  = PH_HELD;
                        n_status = ST_BADID;
                    end else begin
                        n_off   = off_inc;
                        n_phase = PH_FIXED;
                    end
                end
                PH_FIXED: begin
                    n_off = off_inc;
                    if (off_inc >= FIXED_LEN) begin
                        st       = settle(FROM_XLEN, c_flags, off_inc, i_header_limit);
                        n_phase  = st.phase;
                        n_status = st.status;
                    end
                end
                PH_XLEN0: begin
                    n_xrem  = {8'd0, i_data_byte};
                    n_off   = off_inc;
                    n_phase = PH_XLEN1;
                end
                PH_XLEN1: begin
                    n_xrem = xlen;
                    n_off  = off_inc;
                    if (({1'b0, off_inc} + (LIMIT_W+1)'(xlen)) > {1'b0, i_header_limit}) begin
                        n_phase  = PH_HELD;
                        n_status = ST_LIMIT;
                    end else if (xlen == 16'd0) begin
                        st       = settle(FROM_NAME, c_flags, off_inc, i_header_limit);
                        n_phase  = st.phase;
                        n_status = st.status;
                    end else begin
                        n_phase = PH_XDATA;
                    end
                end
                PH_XDATA: begin
                    n_off  = off_inc;
                    n_xrem = xdec;
                    if (xdec == 16'd0) begin
                        st       = settle(FROM_NAME, c_flags, off_inc, i_header_limit);
                        n_phase  = st.phase;
                        n_status = st.status;
                    end
                end
                PH_NAME, PH_COMMENT: begin
                    n_off = off_inc;
                    if (i_data_byte == 8'd0) begin
                        st       = settle((c_phase == PH_NAME) ? FROM_COMMENT : FROM_CRC,
                                          c_flags, off_inc, i_header_limit);
                        n_phase  = st.phase;
                        n_status = st.status;
                    end else if (off_inc >= i_header_limit) begin
                        n_phase  = PH_HELD;
                        n_status = ST_LIMIT;
                    end
                end
                PH_CRC0: begin
                    n_crclo = i_data_byte;
                    n_off   = off_inc;
                    n_phase = PH_CRC1;
                end
                PH_CRC1: begin
                    if ({i_data_byte, c_crclo} != ~c_crc[15:0]) begin
                        n_phase  = PH_HELD;
                        n_status = ST_BADCRC;
                    end else begin
                        n_off    = off_inc;
                        n_phase  = PH_HELD;
                        n_status = ST_DONE;
                    end
                end
                default: begin
                    n_phase  = PH_HELD;
                    n_status = ST_BADID;
                end
            endcase
        end

        o_result.status        = n_status;
        o_result.header_length = (n_status == ST_DONE) ? n_off : '0;
        o_result.flag_bits     = n_flags;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_ID1;
            r_off    <= '0;
            r_crc    <= CRC_PRESET;
            r_flags  <= 8'd0;
            r_xrem   <= 16'd0;
            r_crclo  <= 8'd0;
            r_status <= ST_MORE;
        end else if (i_en) begin
            r_phase  <= n_phase;
            r_off    <= n_off;
            r_crc    <= n_crc;
            r_flags  <= n_flags;
            r_xrem   <= n_xrem;
            r_crclo  <= n_crclo;
            r_status <= n_status;
        end
    end

    a_status_only_when_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_HELD) || (r_status == ST_MORE))
        else $error("nonzero status outside held phase");

    a_held_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_HELD && i_en && !i_first) |=>
            (r_phase == PH_HELD && r_status == $past(r_status)))
        else $error("held status changed without first byte");

    a_phase_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_phase))
        else $error("parse phase not one-hot");

endmodule

@@ rtl/gzip_header_parser.sv @@
// Top level of the gzip member header parser: stream ports, limit register, result register.
//
// Input stream s_axis: one header byte per item from offset zero; tuser marks the byte at
// offset zero and restarts parsing. Output stream m_axis: one status item per input item,
// carrying status, header length (valid with status done) and the received flag byte.
// Configuration: i_cfg_we writes i_cfg_wdata into the header limit (file size minus the
// 8-byte footer); write it only while the block is idle.
// Result: registered; a byte's result appears on m_axis in the cycle after it is accepted.
// Throughput: one byte per cycle unless m_axis stalls; the CRC-32 byte update and the phase
// update sit in one combinational stage between the parse state and result registers.
// Stall: the result register holds while m_axis_tready is low; s_axis_tready stays high
// as long as the result register is empty or is being emptied in the same cycle.
// Reset: synchronous, active low; the parser waits for the first id byte, the limit is
// zero and no result is pending. A byte after reset without tuser is parsed as offset zero.
// Once done or failed, the status repeats for every byte until the next tuser byte.
module gzip_header_parser (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [gzhp_pkg::LIMIT_W-1:0]  i_cfg_wdata,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [7:0]                    s_axis_tdata,  // [7:0] data_byte
    input  logic                          s_axis_tuser,  // [0] first
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [gzhp_pkg::OUT_W-1:0]    m_axis_tdata   // [2:0] status, [34:3] header_length,
                                                         // [42:35] flag_bits, [47:43] zero
);
    import gzhp_pkg::*;

    logic [LIMIT_W-1:0] r_header_limit;
    logic               r_out_valid;
    t_result            r_out;
    t_result            result;
    logic               accept;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    gzhp_core u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (accept),
        .i_data_byte    (s_axis_tdata),
        .i_first        (s_axis_tuser),
        .i_header_limit (r_header_limit),
        .o_result       (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header_limit <= '0;
        end else if (i_cfg_we) begin
            r_header_limit <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {(OUT_W - $bits(t_result))'(0), r_out};

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with empty result register");

    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> m_axis_tvalid)
        else $error("accepted item produced no result");

    a_length_only_when_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (r_out.status == ST_DONE || r_out.header_length == '0))
        else $error("header length without completed header");

endmodule
